FILE: rtl/core/rolling_hash_string_matcher_macros.svh
// Assertion macros for the rolling hash string matcher.
`ifndef ROLLING_HASH_STRING_MATCHER_MACROS_SVH
`define ROLLING_HASH_STRING_MATCHER_MACROS_SVH
`ifndef SYNTHESIS
`define RHSM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RHSM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define RHSM_ASSERT(lbl, clk, rst, prop, msg)
`define RHSM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

FILE: rtl/core/rhsm_pkg.sv
package rhsm_pkg;

   localparam int MAX_PATTERN  = 64;
   localparam int PTR_W        = $clog2(MAX_PATTERN);
   localparam int LEN_W        = $clog2(MAX_PATTERN + 1);
   localparam int LETTER_W     = 5;
   localparam int LETTER_MAX   = (1 << LETTER_W) - 1;
   localparam int CNT_W        = 16;
   localparam int HASH_MODULUS = 997;
   localparam int RADIX        = 26;
   localparam int HASH_W       = $clog2(HASH_MODULUS);

   // largest value handed to the modular reducer
   localparam int RED_MAX_A    = (HASH_MODULUS - 1) * RADIX + LETTER_MAX;
   localparam int RED_MAX_B    = (HASH_MODULUS - 1) * LETTER_MAX;
   localparam int RED_MAX      = (RED_MAX_A > RED_MAX_B) ? RED_MAX_A : RED_MAX_B;
   localparam int RED_W        = $clog2(RED_MAX + 1);
   localparam int RED_SHIFT    = RED_W + 1;
   localparam int RECIP        = (1 << RED_SHIFT) / HASH_MODULUS;
   localparam int RECIP_W      = $clog2(RECIP + 1);
   localparam int PROD_W       = RED_W + RECIP_W;

   localparam logic KIND_PATTERN = 1'b0;
   localparam logic KIND_TEXT    = 1'b1;

   typedef struct packed {
      logic             start;
      logic [RED_W-1:0] x;
   } rhsm_red_req_type;

   typedef struct packed {
      logic              done;
      logic [HASH_W-1:0] r;
   } rhsm_red_rsp_type;

endpackage

FILE: rtl/core/rhsm_ram.sv
module rhsm_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 5
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/rhsm_modred.sv
`include "rolling_hash_string_matcher_macros.svh"

module rhsm_modred
   import rhsm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  rhsm_red_req_type red_req,
   output rhsm_red_rsp_type red_rsp
);

   // x mod M via reciprocal: q estimate is q or q-1, one correcting subtract
   logic                       v0_ff, v1_ff, v2_ff, done_ff;
   logic [RED_W-1:0]           x0_ff, x1_ff, x2_ff, qm2_ff;
   logic [PROD_W-1:0]          p1_ff;
   logic [HASH_W-1:0]          r_ff;
   logic [PROD_W-RED_SHIFT-1:0] q1;
   logic [RED_W-1:0]           diff;
   logic [HASH_W:0]            d3;
   logic [HASH_W:0]            r_in;

   assign q1   = p1_ff[PROD_W-1:RED_SHIFT];
   assign diff = x2_ff - qm2_ff;
   assign d3   = diff[HASH_W:0];
   assign r_in = (d3 >= (HASH_W+1)'(HASH_MODULUS)) ? d3 - (HASH_W+1)'(HASH_MODULUS) : d3;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff   <= 1'b0;
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         v0_ff   <= red_req.start;
         v1_ff   <= v0_ff;
         v2_ff   <= v1_ff;
         done_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      x0_ff  <= red_req.x;
      x1_ff  <= x0_ff;
      p1_ff  <= PROD_W'(x0_ff) * PROD_W'(RECIP);
      x2_ff  <= x1_ff;
      qm2_ff <= RED_W'(RED_W'(q1) * RED_W'(HASH_MODULUS));
      r_ff   <= r_in[HASH_W-1:0];
   end

   assign red_rsp.done = done_ff;
   assign red_rsp.r    = r_ff;

   `RHSM_ASSERT(a_red_latency, clock, reset, red_req.start |-> ##4 red_rsp.done, "reducer result missing")
   `RHSM_ASSERT(a_red_range, clock, reset, red_rsp.done |-> red_rsp.r < HASH_W'(HASH_MODULUS), "residue out of range")
   `RHSM_ASSERT(a_red_quot, clock, reset, v2_ff |-> x2_ff >= qm2_ff, "quotient estimate too large")

endmodule

FILE: rtl/core/rolling_hash_string_matcher.sv
// Pattern letter: the next transfer is taken after two chained reductions (hash, then top
// weight), after only the hash reduction for the first letter, and with no reduction for a
// letter past the store. Text letter, full window: the drop-term reduction, then the roll
// reduction, then the result; while the window fills only the roll reduction; with no usable
// pattern the result directly. On a hash hit a compare follows, one stored letter pair read per cycle.
// Reset is synchronous and clears all control state; the RAMs are not cleared.
`include "rolling_hash_string_matcher_macros.svh"

module rolling_hash_string_matcher
   import rhsm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // [4:0] letter
   input  logic        req_tuser,  // kind
   input  logic        req_tlast,  // last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // match, hash_hit, found, window_start[15:0],
                                   // pattern_overflow
   output logic        rsp_tlast   // text_end
);

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_PHASH = 9'b000000010,
      S_PTW   = 9'b000000100,
      S_TRD   = 9'b000001000,
      S_TSUB  = 9'b000010000,
      S_TGO   = 9'b000100000,
      S_TROLL = 9'b001000000,
      S_CMP   = 9'b010000000,
      S_OUT   = 9'b100000000
   } state_type;

   state_type         state_ff, state_in;
   logic [HASH_W-1:0] phash_ff, phash_in, thash_ff, thash_in, tw_ff, tw_in;
   logic [LEN_W-1:0]  len_ff, len_in, fill_ff, fill_in, j_ff, j_in;
   logic [CNT_W-1:0]  count_ff, count_in, ws_ff, ws_in;
   logic [PTR_W-1:0]  wp_ff, wp_in, rp_ff, rp_in;
   logic              found_ff, found_in, complete_ff, complete_in, ovf_ff, ovf_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [LETTER_W-1:0] c_ff, c_in;
   logic              last_ff, last_in, hit_ff, hit_in, match_ff, match_in, cv_ff, cv_in;

   logic              rsp_match_ff, rsp_match_in, rsp_hit_ff, rsp_hit_in;
   logic              rsp_found_ff, rsp_found_in, rsp_last_ff, rsp_last_in;
   logic              rsp_ovf_ff, rsp_ovf_in;
   logic [CNT_W-1:0]  rsp_ws_ff, rsp_ws_in;

   rhsm_red_req_type  red_req;
   rhsm_red_rsp_type  red_rsp;

   logic                pat_we, ring_we;
   logic [PTR_W-1:0]    pat_waddr, pat_raddr, ring_raddr;
   logic [LETTER_W-1:0] pat_q, ring_q, letter;
   logic [LEN_W-1:0]    eff_len;
   logic [HASH_W-1:0]   eff_phash;
   logic [HASH_W:0]     hs_sum, hs_red;
   logic [PTR_W-1:0]    wp_nx, base_nx;
   logic [LEN_W-1:0]    fill_nx;
   logic [CNT_W-1:0]    cnt_nx, ws_nx;
   logic                issue;

   function automatic logic [PTR_W-1:0] ring_back(input logic [PTR_W-1:0] ptr,
                                                  input logic [LEN_W-1:0] len);
      logic [LEN_W-1:0] p;
      p = LEN_W'(ptr);
      if (p >= len) begin
         return PTR_W'(p - len);
      end
      return PTR_W'(LEN_W'(MAX_PATTERN) - len + p);
   endfunction

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] ptr);
      return (ptr == PTR_W'(MAX_PATTERN - 1)) ? '0 : ptr + 1'b1;
   endfunction

   function automatic logic [RED_W-1:0] mul_add(input logic [HASH_W-1:0] h,
                                                input logic [LETTER_W-1:0] c);
      return RED_W'(h) * RED_W'(RADIX) + RED_W'(c);
   endfunction

   assign letter    = req_tdata[LETTER_W-1:0];
   assign eff_len   = complete_ff ? '0 : len_ff;
   assign eff_phash = complete_ff ? '0 : phash_ff;
   assign pat_waddr = eff_len[PTR_W-1:0];
   assign pat_raddr = j_ff[PTR_W-1:0];

   assign hs_sum  = {1'b0, thash_ff} + ((HASH_W+1)'(HASH_MODULUS) - {1'b0, red_rsp.r});
   assign hs_red  = (hs_sum >= (HASH_W+1)'(HASH_MODULUS)) ?
                    hs_sum - (HASH_W+1)'(HASH_MODULUS) : hs_sum;
   assign wp_nx   = ring_next(wp_ff);
   assign base_nx = ring_back(wp_nx, len_ff);
   assign fill_nx = (fill_ff < LEN_W'(MAX_PATTERN)) ? fill_ff + 1'b1 : fill_ff;
   assign cnt_nx  = (&count_ff) ? count_ff : count_ff + 1'b1;
   assign ws_nx   = (cnt_nx >= CNT_W'(len_ff)) ? cnt_nx - CNT_W'(len_ff) : '0;
   assign issue   = (j_ff < len_ff);

   always_comb begin
      state_in     = state_ff;
      phash_in     = phash_ff;
      thash_in     = thash_ff;
      tw_in        = tw_ff;
      len_in       = len_ff;
      fill_in      = fill_ff;
      j_in         = j_ff;
      count_in     = count_ff;
      ws_in        = ws_ff;
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      found_in     = found_ff;
      complete_in  = complete_ff;
      ovf_in       = ovf_ff;
      c_in         = c_ff;
      last_in      = last_ff;
      hit_in       = hit_ff;
      match_in     = match_ff;
      cv_in        = cv_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_match_in = rsp_match_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_found_in = rsp_found_ff;
      rsp_ws_in    = rsp_ws_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      red_req      = '0;
      pat_we       = 1'b0;
      ring_we      = 1'b0;
      ring_raddr   = ring_back(wp_ff, len_ff);

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               c_in    = letter;
               last_in = req_tlast;
               if (req_tuser == KIND_PATTERN) begin
                  if (complete_ff) begin
                     phash_in    = '0;
                     tw_in       = HASH_W'(1);
                     len_in      = '0;
                     complete_in = 1'b0;
                     ovf_in      = 1'b0;
                     thash_in    = '0;
                     count_in    = '0;
                     found_in    = 1'b0;
                     wp_in       = '0;
                     fill_in     = '0;
                  end
                  if (eff_len >= LEN_W'(MAX_PATTERN)) begin
                     ovf_in = 1'b1;
                     if (req_tlast) begin
                        complete_in = 1'b1;
                     end
                  end else begin
                     pat_we        = 1'b1;
                     red_req.start = 1'b1;
                     red_req.x     = mul_add(eff_phash, letter);
                     state_in      = S_PHASH;
                  end
               end else begin
                  match_in = 1'b0;
                  hit_in   = 1'b0;
                  ws_in    = '0;
                  if (complete_ff && !ovf_ff && (len_ff != '0)) begin
                     if (fill_ff >= len_ff) begin
                        state_in = S_TRD;
                     end else begin
                        red_req.start = 1'b1;
                        red_req.x     = mul_add(thash_ff, letter);
                        state_in      = S_TROLL;
                     end
                  end else begin
                     state_in = S_OUT;
                  end
               end
            end
         end
         S_PHASH: begin
            if (red_rsp.done) begin
               phash_in = red_rsp.r;
               if (len_ff != '0) begin
                  red_req.start = 1'b1;
                  red_req.x     = RED_W'(tw_ff) * RED_W'(RADIX);
                  state_in      = S_PTW;
               end else begin
                  len_in      = len_ff + 1'b1;
                  complete_in = complete_ff | last_ff;
                  state_in    = S_IDLE;
               end
            end
         end
         S_PTW: begin
            if (red_rsp.done) begin
               tw_in       = red_rsp.r;
               len_in      = len_ff + 1'b1;
               complete_in = complete_ff | last_ff;
               state_in    = S_IDLE;
            end
         end
         S_TRD: begin
            red_req.start = 1'b1;
            red_req.x     = RED_W'(ring_q) * RED_W'(tw_ff);
            state_in      = S_TSUB;
         end
         S_TSUB: begin
            if (red_rsp.done) begin
               thash_in = hs_red[HASH_W-1:0];
               state_in = S_TGO;
            end
         end
         S_TGO: begin
            red_req.start = 1'b1;
            red_req.x     = mul_add(thash_ff, c_ff);
            state_in      = S_TROLL;
         end
         S_TROLL: begin
            if (red_rsp.done) begin
               thash_in = red_rsp.r;
               ring_we  = 1'b1;
               wp_in    = wp_nx;
               fill_in  = fill_nx;
               count_in = cnt_nx;
               state_in = S_OUT;
               if (fill_nx >= len_ff) begin
                  hit_in = (red_rsp.r == phash_ff);
                  ws_in  = ws_nx;
                  if (red_rsp.r == phash_ff) begin
                     j_in     = '0;
                     cv_in    = 1'b0;
                     rp_in    = base_nx;
                     state_in = S_CMP;
                  end
               end
            end
         end
         S_CMP: begin
            ring_raddr = rp_ff;
            cv_in      = issue;
            if (issue) begin
               j_in  = j_ff + 1'b1;
               rp_in = ring_next(rp_ff);
            end
            if (cv_ff) begin
               if (ring_q != pat_q) begin
                  match_in = 1'b0;
                  state_in = S_OUT;
               end else if (j_ff == len_ff) begin
                  match_in = 1'b1;
                  found_in = 1'b1;
                  state_in = S_OUT;
               end
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_match_in = match_ff;
               rsp_hit_in   = hit_ff;
               rsp_found_in = found_ff;
               rsp_ws_in    = ws_ff;
               rsp_last_in  = last_ff;
               rsp_ovf_in   = ovf_ff;
               if (last_ff) begin
                  thash_in = '0;
                  count_in = '0;
                  found_in = 1'b0;
                  wp_in    = '0;
                  fill_in  = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phash_ff     <= '0;
         thash_ff     <= '0;
         tw_ff        <= HASH_W'(1);
         len_ff       <= '0;
         fill_ff      <= '0;
         count_ff     <= '0;
         wp_ff        <= '0;
         found_ff     <= 1'b0;
         complete_ff  <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cv_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phash_ff     <= phash_in;
         thash_ff     <= thash_in;
         tw_ff        <= tw_in;
         len_ff       <= len_in;
         fill_ff      <= fill_in;
         count_ff     <= count_in;
         wp_ff        <= wp_in;
         found_ff     <= found_in;
         complete_ff  <= complete_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         cv_ff        <= cv_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff         <= j_in;
      rp_ff        <= rp_in;
      ws_ff        <= ws_in;
      c_ff         <= c_in;
      last_ff      <= last_in;
      hit_ff       <= hit_in;
      match_ff     <= match_in;
      rsp_match_ff <= rsp_match_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_found_ff <= rsp_found_in;
      rsp_ws_ff    <= rsp_ws_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   rhsm_ram #(
      .DEPTH (MAX_PATTERN),
      .WIDTH (LETTER_W)
   ) u_pattern_ram (
      .clock   (clock),
      .wr_en   (pat_we),
      .wr_addr (pat_waddr),
      .wr_data (letter),
      .rd_addr (pat_raddr),
      .rd_data (pat_q)
   );

   rhsm_ram #(
      .DEPTH (MAX_PATTERN),
      .WIDTH (LETTER_W)
   ) u_ring_ram (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (wp_ff),
      .wr_data (c_ff),
      .rd_addr (ring_raddr),
      .rd_data (ring_q)
   );

   rhsm_modred u_modred (
      .clock   (clock),
      .reset   (reset),
      .red_req (red_req),
      .red_rsp (red_rsp)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_ovf_ff, rsp_ws_ff, rsp_found_ff, rsp_hit_ff, rsp_match_ff};
   assign rsp_tlast  = rsp_last_ff;

   `RHSM_ASSERT(a_match_hit, clock, reset, rsp_valid_ff && rsp_match_ff |-> rsp_hit_ff && rsp_found_ff, "match without hash hit")
   `RHSM_ASSERT(a_len_fill, clock, reset, 1'b1 |-> len_ff <= LEN_W'(MAX_PATTERN) && fill_ff <= LEN_W'(MAX_PATTERN), "length or fill out of range")
   `RHSM_ASSERT(a_red_owner, clock, reset, red_rsp.done |-> state_ff == S_PHASH || state_ff == S_PTW || state_ff == S_TSUB || state_ff == S_TROLL, "reducer result dropped")
   `RHSM_ASSERT_NEXT(a_hash_range, clock, reset, red_rsp.done, thash_ff < HASH_W'(HASH_MODULUS) && phash_ff < HASH_W'(HASH_MODULUS) && tw_ff < HASH_W'(HASH_MODULUS), "hash state out of range")

endmodule

FILE: sim/rolling_hash_string_matcher_check.sv
`timescale 1ns / 100ps

module rolling_hash_string_matcher_check
   import rhsm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tuser,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic        rsp_tlast,
   output int          error_count,
   output int          pending_count
);

   typedef struct packed {
      logic        is_match;
      logic        hash_hit;
      logic        found;
      logic [15:0] window_start;
      logic        text_end;
      logic        pattern_overflow;
   } scan_verdict_type;

   logic [LETTER_W-1:0] pattern_mem [MAX_PATTERN];
   logic [LETTER_W-1:0] window_mem  [MAX_PATTERN];
   int unsigned pattern_hash;
   int unsigned window_hash;
   int unsigned top_weight;
   int unsigned pattern_len;
   int unsigned text_count;
   int unsigned ring_wp;
   int unsigned ring_fill;
   bit found_q;
   bit pattern_done;
   bit overflow_q;
   scan_verdict_type verdict_q [$];
   int mismatches = 0;
   int waiting = 0;

   assign error_count   = mismatches;
   assign pending_count = waiting;

   task automatic clear_text();
      window_hash = 0;
      text_count  = 0;
      found_q     = 1'b0;
      ring_wp     = 0;
      ring_fill   = 0;
   endtask

   task automatic clear_pattern();
      pattern_hash = 0;
      top_weight   = 1;
      pattern_len  = 0;
      pattern_done = 1'b0;
      overflow_q   = 1'b0;
   endtask

   function automatic bit window_matches();
      int unsigned base;
      base = (ring_wp + MAX_PATTERN - pattern_len) % MAX_PATTERN;
      for (int unsigned j = 0; j < pattern_len; j++) begin
         if (window_mem[(base + j) % MAX_PATTERN] != pattern_mem[j])
            return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic take_pattern_letter(input logic [LETTER_W-1:0] code, input logic last_mark);
      if (pattern_done) begin
         clear_pattern();
         clear_text();
      end
      if (pattern_len >= MAX_PATTERN) begin
         overflow_q = 1'b1;
      end else begin
         pattern_mem[pattern_len] = code;
         pattern_hash = (pattern_hash * RADIX + code) % HASH_MODULUS;
         if (pattern_len >= 1)
            top_weight = (top_weight * RADIX) % HASH_MODULUS;
         pattern_len++;
      end
      if (last_mark)
         pattern_done = 1'b1;
   endtask

   task automatic take_text_letter(input logic [LETTER_W-1:0] code, input logic last_mark);
      scan_verdict_type v;
      int unsigned h;
      int unsigned drop;
      v = '0;
      if (pattern_done && !overflow_q && pattern_len >= 1) begin
         h = window_hash;
         if (ring_fill >= pattern_len) begin
            drop = (window_mem[(ring_wp + MAX_PATTERN - pattern_len) % MAX_PATTERN]
                    * top_weight) % HASH_MODULUS;
            h = (h + HASH_MODULUS - drop) % HASH_MODULUS;
         end
         window_hash = (h * RADIX + code) % HASH_MODULUS;
         window_mem[ring_wp] = code;
         ring_wp = (ring_wp + 1) % MAX_PATTERN;
         if (ring_fill < MAX_PATTERN)
            ring_fill++;
         if (text_count < 65535)
            text_count++;
         if (ring_fill >= pattern_len) begin
            v.hash_hit = (window_hash == pattern_hash);
            if (v.hash_hit)
               v.is_match = window_matches();
            if (v.is_match)
               found_q = 1'b1;
            v.window_start = (text_count >= pattern_len) ? 16'(text_count - pattern_len) : 16'd0;
         end
      end
      v.found            = found_q;
      v.text_end         = last_mark;
      v.pattern_overflow = overflow_q;
      verdict_q.push_back(v);
      if (last_mark)
         clear_text();
   endtask

   task automatic compare_field(input string field, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", field, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      scan_verdict_type want;
      if (reset) begin
         clear_pattern();
         clear_text();
         verdict_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (verdict_q.size() == 0) begin
               $error("response transfer with no result expected");
               mismatches++;
            end else begin
               want = verdict_q.pop_front();
               compare_field("match", want.is_match, rsp_tdata[0]);
               compare_field("hash_hit", want.hash_hit, rsp_tdata[1]);
               compare_field("found", want.found, rsp_tdata[2]);
               compare_field("window_start", want.window_start, rsp_tdata[18:3]);
               compare_field("pattern_overflow", want.pattern_overflow, rsp_tdata[19]);
               compare_field("text_end", want.text_end, rsp_tlast);
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == KIND_PATTERN)
               take_pattern_letter(req_tdata[LETTER_W-1:0], req_tlast);
            else
               take_text_letter(req_tdata[LETTER_W-1:0], req_tlast);
         end
      end
      waiting <= verdict_q.size();
   end

endmodule

FILE: sim/rolling_hash_string_matcher_test.sv
`timescale 1ns / 100ps

module rolling_hash_string_matcher_test;
   import rhsm_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   int          error_count;
   int          pending_count;

   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;
   int sent_items = 0;
   logic [LETTER_W-1:0] pattern_q [$];
   logic [LETTER_W-1:0] text_q [$];

   rolling_hash_string_matcher u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   rolling_hash_string_matcher_check u_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= !rsp_idle_on || ($urandom_range(0, 99) >= 14);
   end

   task automatic put_letter(input logic kind, input logic [LETTER_W-1:0] code,
                             input logic last_mark);
      while (req_idle_on && $urandom_range(0, 99) < 14) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= 8'(code);
      req_tuser  <= kind;
      req_tlast  <= last_mark;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      sent_items++;
   endtask

   task automatic load_pattern(input int len, input int top_code);
      logic [LETTER_W-1:0] code;
      pattern_q.delete();
      for (int i = 0; i < len; i++) begin
         code = LETTER_W'($urandom_range(0, top_code));
         pattern_q.push_back(code);
         put_letter(KIND_PATTERN, code, i == len - 1);
      end
   endtask

   // random letters with copies of the pattern spliced in
   task automatic run_text(input int len, input int top_code, input int copy_pct);
      text_q.delete();
      while (text_q.size() < len) begin
         if (pattern_q.size() > 0 && text_q.size() + pattern_q.size() <= len &&
             $urandom_range(0, 99) < copy_pct)
            foreach (pattern_q[i]) text_q.push_back(pattern_q[i]);
         else
            text_q.push_back(LETTER_W'($urandom_range(0, top_code)));
      end
      foreach (text_q[i])
         put_letter(KIND_TEXT, text_q[i], i == len - 1);
   endtask

   initial begin
      int pick;
      int plen;
      int top_code;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // text before any pattern, and text during an unfinished pattern
      put_letter(KIND_TEXT, 5'd31, 1'b0);
      put_letter(KIND_TEXT, 5'd0, 1'b1);
      put_letter(KIND_PATTERN, 5'd0, 1'b0);
      put_letter(KIND_TEXT, 5'd1, 1'b0);
      put_letter(KIND_PATTERN, 5'd1, 1'b1);
      put_letter(KIND_TEXT, 5'd0, 1'b0);
      put_letter(KIND_TEXT, 5'd1, 1'b0);
      put_letter(KIND_TEXT, 5'd1, 1'b0);
      put_letter(KIND_TEXT, 5'd0, 1'b0);
      put_letter(KIND_TEXT, 5'd1, 1'b0);
      put_letter(KIND_TEXT, 5'd26, 1'b1);
      // codes above Z
      put_letter(KIND_PATTERN, 5'd31, 1'b0);
      put_letter(KIND_PATTERN, 5'd26, 1'b1);
      put_letter(KIND_TEXT, 5'd31, 1'b0);
      put_letter(KIND_TEXT, 5'd26, 1'b0);
      put_letter(KIND_TEXT, 5'd31, 1'b0);
      put_letter(KIND_TEXT, 5'd26, 1'b1);
      put_letter(KIND_PATTERN, 5'd0, 1'b1);
      put_letter(KIND_TEXT, 5'd0, 1'b0);
      put_letter(KIND_TEXT, 5'd0, 1'b0);
      put_letter(KIND_TEXT, 5'd31, 1'b1);
      put_letter(KIND_PATTERN, 5'd25, 1'b1);
      put_letter(KIND_TEXT, 5'd25, 1'b1);

      // overlong pattern, then a full-size one across ring wrap
      load_pattern(MAX_PATTERN + 2, 31);
      run_text(5, 31, 0);
      load_pattern(MAX_PATTERN, 2);
      run_text(3 * MAX_PATTERN, 2, 40);

      while (sent_items < 1350) begin
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            repeat ($urandom_range(1, 6))
               put_letter(1'($urandom_range(0, 1)), LETTER_W'($urandom_range(0, 31)),
                          $urandom_range(0, 3) == 0);
         end else begin
            plen = (pick < 16) ? $urandom_range(20, MAX_PATTERN) : $urandom_range(1, 6);
            top_code = ($urandom_range(0, 4) == 0) ? 31 : $urandom_range(1, 3);
            load_pattern(plen, top_code);
            repeat ($urandom_range(1, 3))
               run_text($urandom_range(1, plen + 40), top_code, 30);
         end
      end

      // long stretch with no idling on either side
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      load_pattern(4, 2);
      run_text(150, 2, 30);

      @(posedge clock);
      req_tvalid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #20000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
